// File: rtl/core/lphd_pkg.sv
package lphd_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int LIST_DEPTH_DEF  = 1024;
	localparam int HANDLE_BITS_DEF = 16;
	localparam int HASH_BITS       = 32;
	localparam logic [10:0] TABLE_SIZE_RST = 11'd1024;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_HANDLE = 2'd3
	} status_t;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [15:0] handle;
		logic [15:0] key_short;
		logic [31:0] key_word_a;
		logic [31:0] key_word_b;
		logic [31:0] key_word_c;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  bucket;
		logic [10:0] live_count;
	} res_t;

	function automatic logic [31:0] key_hash(input logic [15:0] ks, input logic [31:0] a,
		input logic [31:0] b, input logic [31:0] c);
		logic [31:0] t;
		t = {16'd0, ks} ^ (b << 8);
		t = t << 3;
		t = t ^ c;
		t = t << 5;
		return t ^ (b >> 16) ^ a;
	endfunction

endpackage

// File: rtl/core/lphd_mod.sv
// Restoring remainder, one dividend bit per cycle.
module lphd_mod #(
	parameter int TABLE_DEPTH = lphd_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  logic [31:0]                     dividend,
	input  logic [$clog2(TABLE_DEPTH):0]    divisor,
	output logic                            done,
	output logic [$clog2(TABLE_DEPTH)-1:0]  rem
);
	localparam int TW = $clog2(TABLE_DEPTH);
	localparam int SW = TW + 1;

	logic [31:0]   q_q;
	logic [TW-1:0] r_q;
	logic [5:0]    cnt_q;
	logic          done_q;
	logic [SW-1:0] rs;

	assign rs = {r_q, q_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			q_q    <= '0;
			r_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				q_q   <= dividend;
				r_q   <= '0;
				cnt_q <= 6'd32;
			end else if (cnt_q != 6'd0) begin
				q_q   <= q_q << 1;
				r_q   <= (rs >= divisor) ? TW'(rs - divisor) : TW'(rs);
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q;
endmodule

// File: rtl/core/linear_probe_hash_delete.sv
// Hash table with linear probing and a dense handle list. After reset the block
// clears every bucket, one per cycle, with busy high. A transaction is taken when
// start is high and busy is low; busy then stays high until the result is shown
// on result for exactly one cycle with done high. The receiver cannot stall, so
// capture result whenever done is high. Each home bucket is computed in the shared
// remainder unit; each probed bucket and each scanned list entry is read through
// the memory read port. A remove also rehashes each moved cluster entry in the
// same way. Write table_size only while idle.
module linear_probe_hash_delete #(
	parameter int TABLE_DEPTH = lphd_pkg::TABLE_DEPTH_DEF,
	parameter int LIST_DEPTH  = lphd_pkg::LIST_DEPTH_DEF,
	parameter int HANDLE_BITS = lphd_pkg::HANDLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lphd_pkg::cmd_t      cmd,
	output logic                busy,
	output logic                done,
	output lphd_pkg::res_t      result,
	input  logic                cfg_we,
	input  logic [10:0]         cfg_data
);
	localparam int TW = $clog2(TABLE_DEPTH);
	localparam int SW = TW + 1;
	localparam int LW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int HB = HANDLE_BITS;

	typedef enum logic [10:0] {
		S_CLEAR = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_MODW  = 11'b00000000100,
		S_LRD   = 11'b00000001000,
		S_LCK   = 11'b00000010000,
		S_LMV   = 11'b00000100000,
		S_PRD   = 11'b00001000000,
		S_PCK   = 11'b00010000000,
		S_CRD   = 11'b00100000000,
		S_CCK   = 11'b01000000000,
		S_FIN   = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [10:0]   ts_q;
	logic [SW-1:0] size_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] i_q;
	logic [TW-1:0] clr_q;
	logic [TW-1:0] home_q, p_idx_q, c_idx_q;
	logic [SW-1:0] p_n_q, c_n_q;
	logic          act_q, re_q;
	logic [HB-1:0] h_q, moved_q;
	logic [31:0]   hash_q, mhash_q;
	logic [1:0]    status_q;
	logic [TW-1:0] where_q;
	logic          done_q;
	lphd_pkg::res_t res_q;

	logic [HB-1:0] bh_mem [TABLE_DEPTH];
	logic [31:0]   hs_mem [TABLE_DEPTH];
	logic [HB-1:0] dl_mem [LIST_DEPTH];
	logic [HB-1:0] bh_rd_q, dl_rd_q;
	logic [31:0]   hs_rd_q;

	logic          bh_we, hs_we, dl_we;
	logic [TW-1:0] bh_waddr, hs_waddr, bh_raddr;
	logic [LW-1:0] dl_waddr, dl_raddr;
	logic [HB-1:0] bh_wdata, dl_wdata;
	logic [31:0]   hs_wdata;

	logic          mod_go, mod_done;
	logic [31:0]   mod_din;
	logic [TW-1:0] mod_rem;

	logic [HB-1:0] h_in;
	logic [31:0]   hash_in, ts32, size_n;
	logic [TW-1:0] p_next, c_next;
	logic [SW-1:0] p_n_next;
	logic [CW-1:0] cm1;
	logic          p_match;

	function automatic logic [TW-1:0] wrap_inc(input logic [TW-1:0] idx,
		input logic [SW-1:0] size);
		logic [SW-1:0] nx;
		nx = {1'b0, idx} + SW'(1);
		return (nx == size) ? '0 : nx[TW-1:0];
	endfunction

	assign h_in    = HB'(cmd.handle);
	assign hash_in = lphd_pkg::key_hash(cmd.key_short, cmd.key_word_a, cmd.key_word_b,
		cmd.key_word_c);
	assign ts32    = 32'(ts_q);
	assign size_n  = (ts32 == 32'd0) ? 32'd1 :
		(ts32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : ts32;

	assign p_next   = wrap_inc(p_idx_q, size_q);
	assign c_next   = wrap_inc(c_idx_q, size_q);
	assign p_n_next = p_n_q + SW'(1);
	assign cm1      = count_q - CW'(1);
	assign p_match  = (re_q || act_q == lphd_pkg::ACT_INSERT) ? (bh_rd_q == '0) :
		(bh_rd_q == h_q);

	lphd_mod #(.TABLE_DEPTH(TABLE_DEPTH)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (mod_go),
		.dividend (mod_din),
		.divisor  (size_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// memory ports and remainder unit start
	always_comb begin
		bh_we    = 1'b0;
		hs_we    = 1'b0;
		dl_we    = 1'b0;
		bh_waddr = p_idx_q;
		hs_waddr = p_idx_q;
		dl_waddr = count_q[LW-1:0];
		bh_wdata = '0;
		hs_wdata = hash_q;
		dl_wdata = h_q;
		mod_go   = 1'b0;
		mod_din  = hash_in;
		case (state_q)
			S_CLEAR: begin
				bh_we    = 1'b1;
				bh_waddr = clr_q;
			end
			S_IDLE: begin
				mod_go = start && (h_in != '0);
			end
			S_LMV: begin
				dl_we    = 1'b1;
				dl_waddr = i_q[LW-1:0];
				dl_wdata = dl_rd_q;
			end
			S_PCK: begin
				if (p_match) begin
					bh_we = 1'b1;
					if (re_q) begin
						bh_wdata = moved_q;
						hs_we    = 1'b1;
						hs_wdata = mhash_q;
					end else if (act_q == lphd_pkg::ACT_INSERT) begin
						bh_wdata = h_q;
						hs_we    = 1'b1;
						dl_we    = 1'b1;
					end
				end
			end
			S_CCK: begin
				if (bh_rd_q != '0) begin
					bh_we    = 1'b1;
					bh_waddr = c_idx_q;
					mod_go   = 1'b1;
					mod_din  = hs_rd_q;
				end
			end
			default: ;
		endcase
	end

	assign bh_raddr = (state_q == S_CRD) ? c_next : p_idx_q;
	assign dl_raddr = (state_q == S_LCK) ? cm1[LW-1:0] : i_q[LW-1:0];

	always_ff @(posedge clk) begin
		if (bh_we) bh_mem[bh_waddr] <= bh_wdata;
		bh_rd_q <= bh_mem[bh_raddr];
	end

	always_ff @(posedge clk) begin
		if (hs_we) hs_mem[hs_waddr] <= hs_wdata;
		hs_rd_q <= hs_mem[c_next];
	end

	always_ff @(posedge clk) begin
		if (dl_we) dl_mem[dl_waddr] <= dl_wdata;
		dl_rd_q <= dl_mem[dl_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			ts_q     <= lphd_pkg::TABLE_SIZE_RST;
			size_q   <= '0;
			count_q  <= '0;
			i_q      <= '0;
			clr_q    <= '0;
			home_q   <= '0;
			p_idx_q  <= '0;
			c_idx_q  <= '0;
			p_n_q    <= '0;
			c_n_q    <= '0;
			act_q    <= 1'b0;
			re_q     <= 1'b0;
			h_q      <= '0;
			moved_q  <= '0;
			hash_q   <= '0;
			mhash_q  <= '0;
			status_q <= lphd_pkg::ST_OK;
			where_q  <= '0;
			done_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) ts_q <= cfg_data;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + TW'(1);
					if (clr_q == TW'(TABLE_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						act_q    <= cmd.action;
						h_q      <= h_in;
						hash_q   <= hash_in;
						size_q   <= SW'(size_n);
						re_q     <= 1'b0;
						where_q  <= '0;
						status_q <= lphd_pkg::ST_OK;
						if (h_in == '0) begin
							status_q <= lphd_pkg::ST_BAD_HANDLE;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_MODW;
						end
					end
				end
				S_MODW: begin
					if (mod_done) begin
						p_idx_q <= mod_rem;
						p_n_q   <= '0;
						home_q  <= mod_rem;
						if (re_q) begin
							state_q <= S_PRD;
						end else if (act_q == lphd_pkg::ACT_INSERT) begin
							if (count_q >= CW'(LIST_DEPTH)) begin
								status_q <= lphd_pkg::ST_FULL;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_PRD;
							end
						end else begin
							i_q     <= '0;
							state_q <= S_LRD;
						end
					end
				end
				S_LRD: begin
					if (i_q == count_q) begin
						p_idx_q <= home_q;
						p_n_q   <= '0;
						state_q <= S_PRD;
					end else begin
						state_q <= S_LCK;
					end
				end
				S_LCK: begin
					if (dl_rd_q == h_q) begin
						state_q <= S_LMV;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_LRD;
					end
				end
				S_LMV: begin
					// last entry fills the hole
					count_q <= cm1;
					p_idx_q <= home_q;
					p_n_q   <= '0;
					state_q <= S_PRD;
				end
				S_PRD: begin
					state_q <= S_PCK;
				end
				S_PCK: begin
					if (p_match) begin
						if (re_q) begin
							c_n_q   <= c_n_q + SW'(1);
							state_q <= S_CRD;
						end else if (act_q == lphd_pkg::ACT_INSERT) begin
							count_q <= count_q + CW'(1);
							where_q <= p_idx_q;
							state_q <= S_FIN;
						end else begin
							where_q <= p_idx_q;
							c_idx_q <= p_idx_q;
							c_n_q   <= SW'(1);
							state_q <= S_CRD;
						end
					end else if (p_n_next == size_q) begin
						if (re_q) begin
							c_n_q   <= c_n_q + SW'(1);
							state_q <= S_CRD;
						end else begin
							status_q <= (act_q == lphd_pkg::ACT_INSERT) ?
								lphd_pkg::ST_FULL : lphd_pkg::ST_NOT_FOUND;
							state_q  <= S_FIN;
						end
					end else begin
						p_n_q   <= p_n_next;
						p_idx_q <= p_next;
						state_q <= S_PRD;
					end
				end
				S_CRD: begin
					if (c_n_q == size_q) begin
						state_q <= S_FIN;
					end else begin
						c_idx_q <= c_next;
						state_q <= S_CCK;
					end
				end
				S_CCK: begin
					// end of cluster, or pull the entry out and rehash it
					if (bh_rd_q == '0) begin
						state_q <= S_FIN;
					end else begin
						moved_q <= bh_rd_q;
						mhash_q <= hs_rd_q;
						re_q    <= 1'b1;
						state_q <= S_MODW;
					end
				end
				S_FIN: begin
					res_q.status     <= status_q;
					res_q.bucket     <= (status_q == lphd_pkg::ST_OK) ? 10'(where_q) : 10'd0;
					res_q.live_count <= 11'(count_q);
					done_q           <= 1'b1;
					state_q          <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;
endmodule
